@@ sv/climate_threshold_controller_assert.svh @@
// ----------------------------------------------------------------------------
// climate_threshold_controller_assert.svh
// Assertion macros shared by the climate threshold controller.
// Each macro expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CLIMATE_THRESHOLD_CONTROLLER_ASSERT_SVH
`define CLIMATE_THRESHOLD_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define CTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/ctc_pkg.sv @@
// ----------------------------------------------------------------------------
// ctc_pkg
// Types and constants shared by the climate threshold controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ctc_pkg;

	localparam logic [9:0] DUTY_FULL = 10'd1000;

	// Quotient is at most 1000, so ten restoring steps suffice.
	localparam int DIV_STEPS = 10;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		REG_TEMP_MIN     = 3'd0,
		REG_TEMP_MAX     = 3'd1,
		REG_LIGHT_MIN    = 3'd2,
		REG_LIGHT_MAX    = 3'd3,
		REG_SOIL_MIN     = 3'd4,
		REG_SOIL_MAX     = 3'd5,
		REG_HUMIDITY_MIN = 3'd6,
		REG_HUMIDITY_MAX = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ALERT_NONE        = 3'd0,
		ALERT_TEMPERATURE = 3'd1,
		ALERT_SOIL        = 3'd2,
		ALERT_LIGHT       = 3'd3,
		ALERT_HUMIDITY    = 3'd4
	} alert_t;

	typedef struct packed {
		logic [7:0] temperature;
		logic [7:0] light_level;
		logic [7:0] soil_level;
		logic [7:0] humidity;
	} sample_t;

	typedef struct packed {
		logic       fan_on;
		logic       heater_on;
		logic       irrigation_on;
		logic [9:0] light_duty;
		logic [2:0] alert_code;
		logic       buzzer_on;
	} result_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;    // capture sample, evaluate thresholds, seed divider
		logic step;    // one restoring division step
		logic commit;  // write the output register
	} cmd_t;

endpackage

`default_nettype wire

@@ sv/climate_threshold_controller.sv @@
// ----------------------------------------------------------------------------
// climate_threshold_controller
// Compares a sensor sample set against eight min/max limits and drives fan,
// heater, irrigation (with hysteresis), lamp duty and a prioritized alert.
// ----------------------------------------------------------------------------
// One sample is worked on at a time. An accepted sample is loaded and
// 1000*(max-level) is formed, the one-bit-per-cycle restoring divider
// gives the lamp duty, and the result is committed to the output
// register once the output is free. A new sample is taken only after the
// previous one is committed. A result that waits on out_stall does not
// block the next sample from being worked on; the commit waits until the
// output register is free. The limit registers accept a write in every
// cycle (cfg_ready is held high) and are meant to be written while no
// sample is in progress.
`default_nettype none

module climate_threshold_controller (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire ctc_pkg::sample_t  sample,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output ctc_pkg::result_t       result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [7:0]        cfg_data
);

	ctc_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	ctc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	ctc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.result    (result)
	);

`include "climate_threshold_controller_assert.svh"

	`CTC_ASSERT_NOW(a_duty_range, out_valid, result.light_duty <= ctc_pkg::DUTY_FULL, "duty high")
	`CTC_ASSERT_NOW(a_buzzer_match, out_valid, result.buzzer_on == (|result.alert_code), "buzzer")
	`CTC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "overlap")
	`CTC_ASSERT_NOW(a_no_commit_when_busy_out, cmd.commit, !out_valid || !out_stall, "overwrite")

endmodule

`default_nettype wire

@@ sv/ctc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ctc_ctrl
// Sequencer: accepts a sample, runs the divider steps, commits the result
// and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	output ctc_pkg::cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_WAIT
	} state_t;

	state_t                  state_q;
	logic [ctc_pkg::CNT_W-1:0] cnt_q;
	logic                    out_valid_q;
	logic                    out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd.load   = (state_q == S_IDLE) && in_valid;
		cmd.step   = (state_q == S_DIV);
		cmd.commit = (state_q == S_WAIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_valid)
						state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ctc_pkg::CNT_W'(ctc_pkg::DIV_STEPS - 1))
						state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/ctc_datapath.sv @@
// ----------------------------------------------------------------------------
// ctc_datapath
// Limit registers, threshold compares, irrigation hysteresis, a restoring
// divider for the lamp duty and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctc_pkg::cmd_t     cmd,
	input  wire logic              cfg_wr,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [7:0]        cfg_data,
	input  wire ctc_pkg::sample_t  sample,
	output ctc_pkg::result_t       result
);

	typedef enum logic [1:0] {
		DUTY_SEL_ZERO,
		DUTY_SEL_FULL,
		DUTY_SEL_DIV
	} duty_sel_t;

	logic [7:0] temp_min_q, temp_max_q, light_min_q, light_max_q;
	logic [7:0] soil_min_q, soil_max_q, hum_min_q, hum_max_q;

	logic             irr_q;
	logic             fan_q, heater_q;
	ctc_pkg::alert_t  alert_q;
	duty_sel_t        duty_sel_q;
	logic [7:0]       divisor_q;
	logic [7:0]       rem_q;
	logic [9:0]       num_q;     // numerator low bits in, quotient bits out
	ctc_pkg::result_t result_q;

	// threshold compares
	logic            t_lo, t_hi, s_lo, s_hi, l_lo, l_hi, h_lo, h_hi;
	logic            irr_next;
	ctc_pkg::alert_t alert_next;
	duty_sel_t       duty_sel_next;
	logic [7:0]      diff, span;
	logic [17:0]     prod;
	logic [8:0]      trial;
	logic            trial_ge;

	always_comb begin
		t_lo = sample.temperature < temp_min_q;
		t_hi = sample.temperature > temp_max_q;
		s_lo = sample.soil_level  < soil_min_q;
		s_hi = sample.soil_level  > soil_max_q;
		l_lo = sample.light_level < light_min_q;
		l_hi = sample.light_level > light_max_q;
		h_lo = sample.humidity    < hum_min_q;
		h_hi = sample.humidity    > hum_max_q;

		// below-minimum wins when the soil limits are crossed
		if (s_lo)
			irr_next = 1'b1;
		else if (s_hi)
			irr_next = 1'b0;
		else
			irr_next = irr_q;

		if (t_lo || t_hi)
			alert_next = ctc_pkg::ALERT_TEMPERATURE;
		else if (s_lo || s_hi)
			alert_next = ctc_pkg::ALERT_SOIL;
		else if (l_lo || l_hi)
			alert_next = ctc_pkg::ALERT_LIGHT;
		else if (h_lo || h_hi)
			alert_next = ctc_pkg::ALERT_HUMIDITY;
		else
			alert_next = ctc_pkg::ALERT_NONE;

		diff = light_max_q - sample.light_level;
		span = light_max_q - light_min_q;
		prod = 18'(diff) * 18'(ctc_pkg::DUTY_FULL);

		if (l_lo)
			duty_sel_next = DUTY_SEL_FULL;
		else if (l_hi)
			duty_sel_next = DUTY_SEL_ZERO;
		else if (span == 8'd0)
			duty_sel_next = DUTY_SEL_FULL;
		else
			duty_sel_next = DUTY_SEL_DIV;

		trial    = {rem_q, num_q[9]};
		trial_ge = (trial >= {1'b0, divisor_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_min_q  <= 8'd0;
			temp_max_q  <= 8'd255;
			light_min_q <= 8'd0;
			light_max_q <= 8'd255;
			soil_min_q  <= 8'd0;
			soil_max_q  <= 8'd255;
			hum_min_q   <= 8'd0;
			hum_max_q   <= 8'd255;
		end else if (cfg_wr) begin
			unique case (ctc_pkg::cfg_idx_t'(cfg_index))
				ctc_pkg::REG_TEMP_MIN:     temp_min_q  <= cfg_data;
				ctc_pkg::REG_TEMP_MAX:     temp_max_q  <= cfg_data;
				ctc_pkg::REG_LIGHT_MIN:    light_min_q <= cfg_data;
				ctc_pkg::REG_LIGHT_MAX:    light_max_q <= cfg_data;
				ctc_pkg::REG_SOIL_MIN:     soil_min_q  <= cfg_data;
				ctc_pkg::REG_SOIL_MAX:     soil_max_q  <= cfg_data;
				ctc_pkg::REG_HUMIDITY_MIN: hum_min_q   <= cfg_data;
				ctc_pkg::REG_HUMIDITY_MAX: hum_max_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			irr_q <= 1'b0;
		else if (cmd.load)
			irr_q <= irr_next;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fan_q      <= t_hi;
			heater_q   <= t_lo;
			alert_q    <= alert_next;
			duty_sel_q <= duty_sel_next;
			divisor_q  <= span;
			// quotient < 1024 keeps the upper bits below the divisor
			rem_q      <= prod[17:10];
			num_q      <= prod[9:0];
		end else if (cmd.step) begin
			rem_q <= trial_ge ? 8'(trial - {1'b0, divisor_q}) : trial[7:0];
			num_q <= {num_q[8:0], trial_ge};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result_q.fan_on        <= fan_q;
			result_q.heater_on     <= heater_q;
			result_q.irrigation_on <= irr_q;
			result_q.alert_code    <= alert_q;
			result_q.buzzer_on     <= (alert_q != ctc_pkg::ALERT_NONE);
			case (duty_sel_q)
				DUTY_SEL_FULL: result_q.light_duty <= ctc_pkg::DUTY_FULL;
				DUTY_SEL_DIV:  result_q.light_duty <= num_q;
				default:       result_q.light_duty <= 10'd0;
			endcase
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for climate_threshold_controller. Sample beats are
// predicted in order of acceptance against shadow copies of the limit
// registers and the irrigation state, and every result beat is compared
// field by field. Directed cases cover field extremes, every alert, the
// irrigation hysteresis, equal and crossed limits. Random traffic then runs
// over several limit settings, with random gaps and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	localparam int IDLE_PCT     = 37;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 16;
	localparam int DUTY_PERIOD  = 1000;
	localparam int PHASES       = 8;
	localparam int PHASE_BEATS  = 112;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	ctc_pkg::sample_t sample    = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	ctc_pkg::result_t result;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [2:0]       cfg_index = '0;
	logic [7:0]       cfg_data  = '0;

	logic [7:0]       limit_reg [8];
	logic             irrigation_active;
	ctc_pkg::result_t expected_controls [$];
	int               mismatches   = 0;
	int               quiet_cycles = 0;
	bit               calm         = 1'b0;

	climate_threshold_controller u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit roll_idle();
		return !calm && ($urandom_range(99) < IDLE_PCT);
	endfunction

	function automatic bit out_of_limits(input logic [7:0] v, input int lo_idx);
		return (v < limit_reg[lo_idx]) || (v > limit_reg[lo_idx + 1]);
	endfunction

	function automatic ctc_pkg::result_t predict_controls(input ctc_pkg::sample_t s);
		ctc_pkg::result_t r;
		ctc_pkg::alert_t  alert;
		int unsigned      lo, hi, lvl, duty;
		// hysteresis: below-min wins when the soil limits are crossed
		if (s.soil_level < limit_reg[ctc_pkg::REG_SOIL_MIN])
			irrigation_active = 1'b1;
		else if (s.soil_level > limit_reg[ctc_pkg::REG_SOIL_MAX])
			irrigation_active = 1'b0;

		if (out_of_limits(s.temperature, ctc_pkg::REG_TEMP_MIN))
			alert = ctc_pkg::ALERT_TEMPERATURE;
		else if (out_of_limits(s.soil_level, ctc_pkg::REG_SOIL_MIN))
			alert = ctc_pkg::ALERT_SOIL;
		else if (out_of_limits(s.light_level, ctc_pkg::REG_LIGHT_MIN))
			alert = ctc_pkg::ALERT_LIGHT;
		else if (out_of_limits(s.humidity, ctc_pkg::REG_HUMIDITY_MIN))
			alert = ctc_pkg::ALERT_HUMIDITY;
		else
			alert = ctc_pkg::ALERT_NONE;

		lvl = s.light_level;
		lo  = limit_reg[ctc_pkg::REG_LIGHT_MIN];
		hi  = limit_reg[ctc_pkg::REG_LIGHT_MAX];
		if (lvl < lo)
			duty = DUTY_PERIOD;
		else if (lvl > hi)
			duty = 0;
		else if (hi == lo)
			duty = DUTY_PERIOD;
		else
			duty = (DUTY_PERIOD * (hi - lvl)) / (hi - lo);

		r.fan_on        = s.temperature > limit_reg[ctc_pkg::REG_TEMP_MAX];
		r.heater_on     = s.temperature < limit_reg[ctc_pkg::REG_TEMP_MIN];
		r.irrigation_on = irrigation_active;
		r.light_duty    = duty[9:0];
		r.alert_code    = alert;
		r.buzzer_on     = (alert != ctc_pkg::ALERT_NONE);
		return r;
	endfunction

	// Random value biased toward the edges of a min/max pair.
	function automatic logic [7:0] near_limit(input int lo_idx);
		int lo, hi, v;
		lo = limit_reg[lo_idx];
		hi = limit_reg[lo_idx + 1];
		case ($urandom_range(3))
			0: v = $urandom_range(255);
			1: v = lo + int'($urandom_range(4)) - 2;
			2: v = hi + int'($urandom_range(4)) - 2;
			default: v = (lo <= hi) ? int'($urandom_range(hi, lo)) : int'($urandom_range(255));
		endcase
		if (v < 0)
			v = 0;
		else if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	task automatic send_sample(input logic [7:0] t, l, s, h);
		@(negedge clk);
		while (roll_idle()) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid           = 1'b1;
		sample.temperature = t;
		sample.light_level = l;
		sample.soil_level  = s;
		sample.humidity    = h;
		do @(posedge clk); while (in_stall);
		expected_controls.push_back(predict_controls(sample));
	endtask

	// Block goes idle once every result is out; extra cycles for margin.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_controls.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input ctc_pkg::cfg_idx_t idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		limit_reg[idx] = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_limits(input logic [7:0] tmin, tmax, lmin, lmax,
			smin, smax, hmin, hmax);
		write_limit(ctc_pkg::REG_TEMP_MIN, tmin);
		write_limit(ctc_pkg::REG_TEMP_MAX, tmax);
		write_limit(ctc_pkg::REG_LIGHT_MIN, lmin);
		write_limit(ctc_pkg::REG_LIGHT_MAX, lmax);
		write_limit(ctc_pkg::REG_SOIL_MIN, smin);
		write_limit(ctc_pkg::REG_SOIL_MAX, smax);
		write_limit(ctc_pkg::REG_HUMIDITY_MIN, hmin);
		write_limit(ctc_pkg::REG_HUMIDITY_MAX, hmax);
	endtask

	// crossed: min written at or above max for every pair
	task automatic random_limits(input bit crossed);
		logic [7:0] a, b, lo, hi;
		for (int k = 0; k < 4; k++) begin
			a = $urandom_range(255);
			b = (k == 1 && $urandom_range(3) == 0) ? a : 8'($urandom_range(255));
			lo = (a < b) ? a : b;
			hi = (a < b) ? b : a;
			if (crossed) begin
				write_limit(ctc_pkg::cfg_idx_t'(2 * k), hi);
				write_limit(ctc_pkg::cfg_idx_t'(2 * k + 1), lo);
			end else begin
				write_limit(ctc_pkg::cfg_idx_t'(2 * k), lo);
				write_limit(ctc_pkg::cfg_idx_t'(2 * k + 1), hi);
			end
		end
	endtask

	task automatic test_reset_limits();
		send_sample(8'h00, 8'h00, 8'h00, 8'h00);
		send_sample(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_sample(8'hAA, 8'hAA, 8'hAA, 8'hAA);
		send_sample(8'h55, 8'h55, 8'h55, 8'h55);
		settle();
	endtask

	task automatic test_directed_limits();
		set_limits(8'd20, 8'd30, 8'd50, 8'd150, 8'd40, 8'd60, 8'd30, 8'd70);
		send_sample(8'd25, 8'd100, 8'd50, 8'd50);
		send_sample(8'd31, 8'd100, 8'd50, 8'd50);
		send_sample(8'd19, 8'd100, 8'd50, 8'd50);
		// irrigation: on, hold, off, hold
		send_sample(8'd25, 8'd100, 8'd39, 8'd50);
		send_sample(8'd25, 8'd100, 8'd50, 8'd50);
		send_sample(8'd25, 8'd100, 8'd61, 8'd50);
		send_sample(8'd25, 8'd100, 8'd50, 8'd50);
		send_sample(8'd25, 8'd49, 8'd50, 8'd50);
		send_sample(8'd25, 8'd151, 8'd50, 8'd50);
		send_sample(8'd25, 8'd50, 8'd50, 8'd50);
		send_sample(8'd25, 8'd150, 8'd50, 8'd50);
		send_sample(8'd25, 8'd100, 8'd50, 8'd29);
		send_sample(8'd25, 8'd100, 8'd50, 8'd71);
		// alert priority
		send_sample(8'd31, 8'd49, 8'd39, 8'd71);
		send_sample(8'd25, 8'd49, 8'd50, 8'd71);
		settle();
	endtask

	task automatic test_special_limits();
		// equal light limits, crossed soil limits
		write_limit(ctc_pkg::REG_LIGHT_MIN, 8'd80);
		write_limit(ctc_pkg::REG_LIGHT_MAX, 8'd80);
		write_limit(ctc_pkg::REG_SOIL_MIN, 8'd60);
		write_limit(ctc_pkg::REG_SOIL_MAX, 8'd40);
		send_sample(8'd25, 8'd80, 8'd50, 8'd50);
		send_sample(8'd25, 8'd79, 8'd70, 8'd50);
		send_sample(8'd25, 8'd81, 8'd35, 8'd50);
		settle();
		// crossed light limits
		write_limit(ctc_pkg::REG_LIGHT_MIN, 8'd200);
		write_limit(ctc_pkg::REG_LIGHT_MAX, 8'd100);
		send_sample(8'd25, 8'd150, 8'd70, 8'd50);
		send_sample(8'd25, 8'd250, 8'd50, 8'd50);
		send_sample(8'd25, 8'd50, 8'd50, 8'd50);
		settle();
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_limits(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
				1: set_limits(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
				2: set_limits(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
						8'd255, 8'd255);
				3: random_limits(1'b1);
				default: random_limits(1'b0);
			endcase
			calm = (p == 5);
			for (int i = 0; i < PHASE_BEATS; i++)
				send_sample(near_limit(ctc_pkg::REG_TEMP_MIN),
						near_limit(ctc_pkg::REG_LIGHT_MIN),
						near_limit(ctc_pkg::REG_SOIL_MIN),
						near_limit(ctc_pkg::REG_HUMIDITY_MIN));
			settle();
		end
		calm = 1'b0;
	endtask

	always @(negedge clk)
		out_stall = roll_idle();

	always @(posedge clk) begin
		ctc_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_controls.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with none expected, actual %p", $time, result);
			end else begin
				want = expected_controls.pop_front();
				check_field("fan_on", want.fan_on, result.fan_on);
				check_field("heater_on", want.heater_on, result.heater_on);
				check_field("irrigation_on", want.irrigation_on, result.irrigation_on);
				check_field("light_duty", want.light_duty, result.light_duty);
				check_field("alert_code", want.alert_code, result.alert_code);
				check_field("buzzer_on", want.buzzer_on, result.buzzer_on);
			end
		end
	end

	// Watchdog: too long without any beat on any channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		limit_reg[ctc_pkg::REG_TEMP_MIN]     = 8'd0;
		limit_reg[ctc_pkg::REG_TEMP_MAX]     = 8'd255;
		limit_reg[ctc_pkg::REG_LIGHT_MIN]    = 8'd0;
		limit_reg[ctc_pkg::REG_LIGHT_MAX]    = 8'd255;
		limit_reg[ctc_pkg::REG_SOIL_MIN]     = 8'd0;
		limit_reg[ctc_pkg::REG_SOIL_MAX]     = 8'd255;
		limit_reg[ctc_pkg::REG_HUMIDITY_MIN] = 8'd0;
		limit_reg[ctc_pkg::REG_HUMIDITY_MAX] = 8'd255;
		irrigation_active                    = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_limits();
		test_directed_limits();
		test_special_limits();
		test_random_traffic();

		if (mismatches == 0 && expected_controls.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+sv
sv/ctc_pkg.sv
sv/ctc_ctrl.sv
sv/ctc_datapath.sv
sv/climate_threshold_controller.sv
tb/testbench.sv
